@@ rtl/core/pbsu_pkg.sv @@
// Shared types and constants for the PCM byte stream unpacker.
// No dependencies; every other file in rtl/core refers to this package.
`timescale 1ns / 1ps

package pbsu_pkg;

  // Channel limits
  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = 3;   // width of the channel field
  localparam int COUNT_W      = 4;   // width of the channel_count register

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_MODE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BIG_ENDIAN    = 2'd2;

  // Sample width codes; the unused code decodes as 16-bit
  localparam logic [1:0] MODE_NIBBLE = 2'd0;
  localparam logic [1:0] MODE_BYTE   = 2'd1;
  localparam logic [1:0] MODE_WORD   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [1:0]         RST_SAMPLE_MODE   = MODE_WORD;
  localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT = 4'd2;

  // Result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_block;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [CH_W-1:0]    channel;
    logic               last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]         sample_mode;
    logic [COUNT_W-1:0] channel_count;
    logic               big_endian;
  } cfg_t;

endpackage

@@ rtl/core/pbsu_decode.sv @@
// Byte decoder: turns one accepted byte into up to two results and keeps
// the byte phase, held byte and channel counter. Depends on pbsu_pkg.
`timescale 1ns / 1ps

module pbsu_decode (
  input  logic               clk,
  input  logic               rst,
  input  pbsu_pkg::cfg_t     cfg,
  input  logic               accept,
  input  pbsu_pkg::in_beat_t beat,
  output pbsu_pkg::out_beat_t res0,
  output pbsu_pkg::out_beat_t res1,
  output logic [1:0]         res_count
);

  logic                         byte_phase;
  logic                         byte_phase_next;
  logic [7:0]                   held_byte;
  logic [7:0]                   held_byte_next;
  logic [pbsu_pkg::CH_W-1:0]    channel_counter;
  logic [pbsu_pkg::CH_W-1:0]    channel_counter_next;

  logic [pbsu_pkg::COUNT_W-1:0] n_active;
  logic [pbsu_pkg::CH_W-1:0]    last_ch;
  logic [pbsu_pkg::CH_W-1:0]    cur_ch;
  logic [pbsu_pkg::COUNT_W-1:0] inc_ch;
  logic [pbsu_pkg::CH_W-1:0]    adv_ch;
  logic [3:0]                   nib_first;
  logic [3:0]                   nib_second;

  // Clamp the channel count to 1..MAX_CHANNELS
  always_comb begin
    if (cfg.channel_count == '0) begin
      n_active = pbsu_pkg::COUNT_W'(1);
    end else if (cfg.channel_count > pbsu_pkg::COUNT_W'(pbsu_pkg::MAX_CHANNELS)) begin
      n_active = pbsu_pkg::COUNT_W'(pbsu_pkg::MAX_CHANNELS);
    end else begin
      n_active = cfg.channel_count;
    end
  end

  assign last_ch = pbsu_pkg::CH_W'(n_active - pbsu_pkg::COUNT_W'(1));

  // Current channel (wraps to 0 if the count dropped below it) and its successor
  assign cur_ch = ({1'b0, channel_counter} < n_active) ? channel_counter : '0;
  assign inc_ch = {1'b0, cur_ch} + pbsu_pkg::COUNT_W'(1);
  assign adv_ch = (inc_ch >= n_active) ? '0 : pbsu_pkg::CH_W'(inc_ch);

  assign nib_first  = cfg.big_endian ? beat.data_byte[7:4] : beat.data_byte[3:0];
  assign nib_second = cfg.big_endian ? beat.data_byte[3:0] : beat.data_byte[7:4];

  // Result and state-update logic
  always_comb begin
    res0                 = '0;
    res1                 = '0;
    res_count            = 2'd0;
    byte_phase_next      = byte_phase;
    held_byte_next       = held_byte;
    channel_counter_next = channel_counter;

    case (cfg.sample_mode)
      pbsu_pkg::MODE_NIBBLE: begin
        // (nib << 12) - 0x8000 is the nibble with its top bit flipped
        res0.sample      = {nib_first ^ 4'h8, 12'h000};
        res0.channel     = '0;
        res0.last_of_run = 1'b0;
        res1.sample      = {nib_second ^ 4'h8, 12'h000};
        res1.channel     = (n_active == pbsu_pkg::COUNT_W'(1)) ? '0 : last_ch;
        res1.last_of_run = 1'b1;
        res_count        = 2'd2;
      end
      pbsu_pkg::MODE_BYTE: begin
        res0.sample          = {beat.data_byte, 8'h00};
        res0.channel         = cur_ch;
        res0.last_of_run     = 1'b1;
        res_count            = 2'd1;
        channel_counter_next = adv_ch;
      end
      default: begin
        // 16-bit: first byte is held, second completes the sample
        if (!byte_phase) begin
          held_byte_next  = beat.data_byte;
          byte_phase_next = 1'b1;
        end else begin
          res0.sample          = cfg.big_endian ? {held_byte, beat.data_byte}
                                                : {beat.data_byte, held_byte};
          res0.channel         = cur_ch;
          res0.last_of_run     = 1'b1;
          res_count            = 2'd1;
          byte_phase_next      = 1'b0;
          channel_counter_next = adv_ch;
        end
      end
    endcase

    // End of block: phase and channel start over
    if (beat.last_in_block) begin
      byte_phase_next      = 1'b0;
      held_byte_next       = '0;
      channel_counter_next = '0;
    end
  end

  // State registers, updated only on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase      <= 1'b0;
      held_byte       <= '0;
      channel_counter <= '0;
    end else if (accept) begin
      byte_phase      <= byte_phase_next;
      held_byte       <= held_byte_next;
      channel_counter <= channel_counter_next;
    end
  end

endmodule

@@ rtl/core/pbsu_result_queue.sv @@
// Small result queue: takes up to two results per cycle, gives one per beat.
// Depends on pbsu_pkg.
`timescale 1ns / 1ps

module pbsu_result_queue (
  input  logic                clk,
  input  logic                rst,
  input  pbsu_pkg::out_beat_t push0,
  input  pbsu_pkg::out_beat_t push1,
  input  logic [1:0]          push_count,
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output pbsu_pkg::out_beat_t out_data
);

  pbsu_pkg::out_beat_t             mem [pbsu_pkg::QUEUE_DEPTH];
  logic [pbsu_pkg::QPTR_W-1:0]     wr_ptr;
  logic [pbsu_pkg::QPTR_W-1:0]     rd_ptr;
  logic [pbsu_pkg::QCNT_W-1:0]     fill;
  logic [pbsu_pkg::QCNT_W-1:0]     fill_next;
  logic                            pop;

  // Room for a full two-result beat regardless of this cycle's pop
  assign has_room  = fill <= pbsu_pkg::QCNT_W'(pbsu_pkg::QUEUE_DEPTH - 2);
  assign out_valid = fill != '0;
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_comb begin
    fill_next = fill + pbsu_pkg::QCNT_W'(push_count) - pbsu_pkg::QCNT_W'(pop);
  end

  // Storage writes
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + pbsu_pkg::QPTR_W'(1)] <= push1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + pbsu_pkg::QPTR_W'(push_count);
      rd_ptr <= rd_ptr + pbsu_pkg::QPTR_W'(pop);
      fill   <= fill_next;
    end
  end

endmodule

@@ rtl/core/pcm_byte_stream_unpacker.sv @@
// PCM byte stream unpacker: one byte per beat in, signed 16-bit tagged samples out.
// Results are registered in the result queue and offered from there.
// Throughput: one byte per cycle in 8- and 16-bit modes while out_ready stays high; in 4-bit
// mode each byte makes two results and the single-beat output port limits the byte rate.
// Reset: synchronous; restores sample_mode=2, channel_count=2, big_endian=0, clears
// phase, held byte, channel counter and the result queue. Depends on pbsu_pkg.
`timescale 1ns / 1ps

module pcm_byte_stream_unpacker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pbsu_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pbsu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pbsu_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pbsu_pkg::out_beat_t                 out_data
);

  pbsu_pkg::cfg_t      cfg;
  pbsu_pkg::out_beat_t res0;
  pbsu_pkg::out_beat_t res1;
  logic [1:0]          res_count;
  logic [1:0]          push_count;
  logic                accept;
  logic                has_room;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_mode   <= pbsu_pkg::RST_SAMPLE_MODE;
      cfg.channel_count <= pbsu_pkg::RST_CHANNEL_COUNT;
      cfg.big_endian    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        pbsu_pkg::REG_SAMPLE_MODE:   cfg.sample_mode   <= cfg_wdata[1:0];
        pbsu_pkg::REG_CHANNEL_COUNT: cfg.channel_count <= cfg_wdata;
        pbsu_pkg::REG_BIG_ENDIAN:    cfg.big_endian    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_ready   = has_room;
  assign accept     = in_valid && in_ready;
  assign push_count = accept ? res_count : 2'd0;

  pbsu_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .beat      (in_data),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count)
  );

  pbsu_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push0      (res0),
    .push1      (res1),
    .push_count (push_count),
    .has_room   (has_room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
